// File: rtl/nss_pkg.sv
package nss_pkg;

  localparam int PERIOD_WIDTH = 25;
  localparam int HOLD_W       = 20;
  localparam int CYCLE_W      = 5;
  localparam int LIGHT_W      = 16;
  localparam int PAT_W        = 6;
  localparam int STEP_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = (PERIOD_WIDTH > HOLD_W) ? PERIOD_WIDTH : HOLD_W;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX   = '1;
  localparam logic [PERIOD_WIDTH-1:0] CHECK_RESET  = PERIOD_WIDTH'(64'd9843750);
  localparam logic [PERIOD_WIDTH-1:0] REST_RESET   = PERIOD_WIDTH'(64'd19687500);
  localparam logic [PERIOD_WIDTH-1:0] RUN_RESET    = PERIOD_WIDTH'(64'd9843750);
  localparam logic [HOLD_W-1:0]       SLOW_RESET   = HOLD_W'(32'd140000);
  localparam logic [HOLD_W-1:0]       FAST_RESET   = HOLD_W'(32'd17500);
  localparam logic [CYCLE_W-1:0]      CYCLES_RESET = CYCLE_W'(32'd24);

  localparam logic [PAT_W-1:0] SLOW_PATS [4] = '{6'h36, 6'h35, 6'h39, 6'h3A};
  localparam logic [PAT_W-1:0] FAST_PATS [4] = '{6'h0A, 6'h09, 6'h05, 6'h06};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_PERIOD   = 3'd0,
    CFG_REST_PERIOD    = 3'd1,
    CFG_RUN_PERIOD     = 3'd2,
    CFG_SLOW_HOLD      = 3'd3,
    CFG_FAST_HOLD      = 3'd4,
    CFG_CYCLES_PER_SEG = 3'd5,
    CFG_LIGHT_THRESH   = 3'd6
  } cfg_idx_t;

  localparam logic ACTION_TICK   = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] check_period;
    logic [PERIOD_WIDTH-1:0] rest_period;
    logic [PERIOD_WIDTH-1:0] run_period;
    logic [HOLD_W-1:0]       slow_hold_ticks;
    logic [HOLD_W-1:0]       fast_hold_ticks;
    logic [CYCLE_W-1:0]      cycles_per_segment;
    logic [LIGHT_W-1:0]      light_threshold;
  } cfg_t;

  typedef struct packed {
    logic [PAT_W-1:0] drive_pattern;
    logic             sweeping;
    logic             night;
  } out_item_t;

  typedef struct packed {
    logic                    sweep_active;
    logic                    use_rest_wait;
    logic [PERIOD_WIDTH-1:0] wait_count;
    logic [PERIOD_WIDTH-1:0] run_count;
    logic                    fast_segment;
    logic [STEP_W-1:0]       step_index;
    logic [CYCLE_W-1:0]      cycle_count;
    logic [HOLD_W-1:0]       hold_count;
    logic                    night_flag;
    logic [PAT_W-1:0]        pattern_reg;
  } st_t;

endpackage

// File: rtl/nss_in_if.sv
interface nss_in_if;
  import nss_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [LIGHT_W-1:0] light_level;

  modport source (output valid, output action, output light_level, input ready);
  modport sink   (input valid, input action, input light_level, output ready);
endinterface

// File: rtl/nss_out_if.sv
interface nss_out_if;
  import nss_pkg::*;

  logic             valid;
  logic             ready;
  logic [PAT_W-1:0] drive_pattern;
  logic             sweeping;
  logic             night;

  modport source (output valid, output drive_pattern, output sweeping, output night,
                  input ready);
  modport sink   (input valid, input drive_pattern, input sweeping, input night,
                  output ready);
endinterface

// File: rtl/nss_cfg_regs.sv
module nss_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output nss_pkg::cfg_t                  cfg
);
  import nss_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHECK_PERIOD:   cfg_nxt.check_period       = cfg_wdata[PERIOD_WIDTH-1:0];
        CFG_REST_PERIOD:    cfg_nxt.rest_period        = cfg_wdata[PERIOD_WIDTH-1:0];
        CFG_RUN_PERIOD:     cfg_nxt.run_period         = cfg_wdata[PERIOD_WIDTH-1:0];
        CFG_SLOW_HOLD:      cfg_nxt.slow_hold_ticks    = cfg_wdata[HOLD_W-1:0];
        CFG_FAST_HOLD:      cfg_nxt.fast_hold_ticks    = cfg_wdata[HOLD_W-1:0];
        CFG_CYCLES_PER_SEG: cfg_nxt.cycles_per_segment = cfg_wdata[CYCLE_W-1:0];
        CFG_LIGHT_THRESH:   cfg_nxt.light_threshold    = cfg_wdata[LIGHT_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_period       <= CHECK_RESET;
      cfg_r.rest_period        <= REST_RESET;
      cfg_r.run_period         <= RUN_RESET;
      cfg_r.slow_hold_ticks    <= SLOW_RESET;
      cfg_r.fast_hold_ticks    <= FAST_RESET;
      cfg_r.cycles_per_segment <= CYCLES_RESET;
      cfg_r.light_threshold    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/nss_core.sv
module nss_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        action,
  input  logic [nss_pkg::LIGHT_W-1:0] light_level,
  input  nss_pkg::cfg_t               cfg,
  output nss_pkg::out_item_t          result
);
  import nss_pkg::*;

  st_t st_r;
  st_t st_nxt;

  logic [PERIOD_WIDTH-1:0] period;
  logic [PERIOD_WIDTH-1:0] run_inc;
  logic [HOLD_W-1:0]       hold_lim;
  logic [HOLD_W-1:0]       hold_inc;
  logic [STEP_W-1:0]       step_inc;
  logic [CYCLE_W-1:0]      cycle_inc;
  logic                    rest_now;

  assign period    = st_r.use_rest_wait ? cfg.rest_period : cfg.check_period;
  assign hold_lim  = st_r.fast_segment ? cfg.fast_hold_ticks : cfg.slow_hold_ticks;
  assign run_inc   = (st_r.run_count < PERIOD_MAX) ? st_r.run_count + 1'b1 : st_r.run_count;
  assign hold_inc  = st_r.hold_count + 1'b1;
  assign step_inc  = st_r.step_index + 1'b1;
  assign cycle_inc = st_r.cycle_count + 1'b1;

  always_comb begin
    st_nxt   = st_r;
    rest_now = 1'b0;
    if (accept) begin
      if (action == ACTION_SAMPLE) begin
        st_nxt.night_flag = (light_level <= cfg.light_threshold);
      end else if (st_r.sweep_active) begin
        st_nxt.run_count = run_inc;
        if (hold_inc < hold_lim) begin
          st_nxt.hold_count = hold_inc;
        end else begin
          st_nxt.hold_count = '0;
          st_nxt.step_index = step_inc;
          // A full four-pattern cycle finished: count it and maybe switch segment or end the run.
          if (step_inc == '0) begin
            st_nxt.cycle_count = cycle_inc;
            if (cycle_inc >= cfg.cycles_per_segment) begin
              st_nxt.cycle_count = '0;
              if (!st_r.fast_segment) begin
                st_nxt.fast_segment = 1'b1;
              end else if (run_inc >= cfg.run_period) begin
                rest_now             = 1'b1;
                st_nxt.sweep_active  = 1'b0;
                st_nxt.use_rest_wait = 1'b1;
                st_nxt.wait_count    = '0;
                st_nxt.night_flag    = 1'b0;
              end else begin
                st_nxt.fast_segment = 1'b0;
              end
            end
          end
          // The last pattern of a run stays on the pins.
          if (!rest_now) begin
            st_nxt.pattern_reg = st_nxt.fast_segment ? FAST_PATS[step_inc]
                                                     : SLOW_PATS[step_inc];
          end
        end
      end else begin
        if (st_r.wait_count < period) begin
          st_nxt.wait_count = st_r.wait_count + 1'b1;
        end else if (!st_r.night_flag) begin
          st_nxt.use_rest_wait = 1'b0;
          st_nxt.wait_count    = '0;
        end else if (cfg.run_period == '0) begin
          st_nxt.use_rest_wait = 1'b1;
          st_nxt.wait_count    = '0;
          st_nxt.night_flag    = 1'b0;
        end else begin
          st_nxt.sweep_active = 1'b1;
          st_nxt.run_count    = '0;
          st_nxt.fast_segment = 1'b0;
          st_nxt.step_index   = '0;
          st_nxt.cycle_count  = '0;
          st_nxt.hold_count   = '0;
          st_nxt.pattern_reg  = SLOW_PATS[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign result.drive_pattern = st_nxt.pattern_reg;
  assign result.sweeping      = st_nxt.sweep_active;
  assign result.night         = st_nxt.night_flag;

`ifndef SYNTHESIS
  a_state_only_on_word: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(st_r))
    else $error("state changed without an accepted word");
  a_sample_keeps_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && action == ACTION_SAMPLE) |=>
      (st_r.sweep_active == $past(st_r.sweep_active)) && $stable(st_r.pattern_reg))
    else $error("light sample disturbed the sweep");
  a_sweep_starts_slow: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.sweep_active) |-> (st_r.pattern_reg == SLOW_PATS[0]) && !st_r.fast_segment)
    else $error("sweep did not start on the first slow pattern");
  a_sweep_ends_rest: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(st_r.sweep_active) |-> st_r.use_rest_wait && !st_r.night_flag
                                 && (st_r.wait_count == '0))
    else $error("sweep ended without entering the rest wait");
`endif

endmodule

// File: rtl/nss_out_buf.sv
module nss_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nss_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output nss_pkg::out_item_t out_data
);
  import nss_pkg::*;

  out_item_t   ent_r [2];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("word pushed into a full result buffer");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd1) |-> (wr_ptr_r == rd_ptr_r))
    else $error("result buffer pointers disagree with count");
`endif

endmodule

// File: rtl/night_sweep_stepper_sequencer.sv
// Night sweep stepper sequencer. Every input word (a timer tick or a light
// sample) gives exactly one result word carrying the drive pattern, the sweep
// flag and the night mark after that word. All counters update in the cycle in
// which the word is accepted, so a word can enter on every clock; a two-word
// result buffer keeps input flowing while up to two results wait for the sink,
// and input stalls only when both are held.
// Configuration writes take effect on the next accepted word.
module night_sweep_stepper_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  nss_in_if.sink                         in_ch,
  nss_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nss_pkg::*;

  cfg_t      cfg;
  out_item_t result;
  out_item_t out_data;
  logic      buf_full;
  logic      in_accept;

  assign in_ch.ready = !buf_full;
  assign in_accept   = in_ch.valid && !buf_full;

  nss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  nss_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .action      (in_ch.action),
    .light_level (in_ch.light_level),
    .cfg         (cfg),
    .result      (result)
  );

  nss_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.drive_pattern = out_data.drive_pattern;
  assign out_ch.sweeping      = out_data.sweeping;
  assign out_ch.night         = out_data.night;

endmodule
